// ----- design/hello_neighbor_liveness_table_unit_assert.svh -----
// assertion helpers used by the neighbor table sequencer
`ifndef HELLO_NEIGHBOR_LIVENESS_TABLE_UNIT_ASSERT_SVH
`define HELLO_NEIGHBOR_LIVENESS_TABLE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HNL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HNL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hnl_pkg.sv -----
package hnl_pkg;

  // request codes
  localparam logic REQ_HELLO = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result event codes
  localparam logic [2:0] EV_NEW       = 3'd0;
  localparam logic [2:0] EV_REFRESHED = 3'd1;
  localparam logic [2:0] EV_STALE     = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_TIMED_OUT = 3'd4;
  localparam logic [2:0] EV_DONE      = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 1'b1;

  localparam logic [7:0] HOLD_TIMEOUT_RST = 8'd10;

  typedef struct packed {
    logic        req_type;
    logic [31:0] source_address;
    logic [15:0] hello_sequence;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] neighbour_address;
    logic        last_of_run;
  } out_item_t;

  // one neighbor entry held by a cell
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] seq_num;
    logic [31:0] heard_time;
  } entry_t;

  // what the whole row of cells does each cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_DROP   = 2'd2,
    OP_APPEND = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   wrap;
    entry_t   back;
    entry_t   fresh;
  } cell_ctl_t;

endpackage

// ----- design/hnl_cell.sv -----
module hnl_cell #(
  parameter int K     = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  hnl_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   count,
  input  logic [CNT_W-1:0]   unscanned,
  input  hnl_pkg::entry_t    next_q,
  output hnl_pkg::entry_t    q
);

  localparam logic [CNT_W-1:0] POS    = CNT_W'(K);
  localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(K + 1);
  localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

  hnl_pkg::entry_t entry_r;
  hnl_pkg::entry_t entry_nxt;

  // per-cell move selection from the broadcast op and fill level
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      hnl_pkg::OP_HOLD: begin
        entry_nxt = entry_r;
      end
      hnl_pkg::OP_ROTATE: begin
        if (POS_P1 < count) begin
          entry_nxt = next_q;
        end else if (POS_P1 == count) begin
          entry_nxt = ctl.wrap;
        end
      end
      hnl_pkg::OP_DROP: begin
        // head takes the back of the unscanned run, the kept run closes up
        if ((K == 0) && (unscanned > ONE)) begin
          entry_nxt = ctl.back;
        end else if ((POS_P1 >= unscanned) && (POS_P1 < count)) begin
          entry_nxt = next_q;
        end
      end
      hnl_pkg::OP_APPEND: begin
        if (POS == count) begin
          entry_nxt = ctl.fresh;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

// ----- design/hnl_seq.sv -----
`include "hello_neighbor_liveness_table_unit_assert.svh"

module hnl_seq #(
  parameter int MAX_NEIGHBOURS = 16,
  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1),
  localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hnl_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hnl_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [hnl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata,
  input  hnl_pkg::entry_t                   cells [MAX_NEIGHBOURS],
  output hnl_pkg::cell_ctl_t                ctl,
  output logic [CNT_W-1:0]                  count,
  output logic [CNT_W-1:0]                  unscanned
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBOURS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_REPLY = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  hnl_pkg::in_item_t  req_r, req_nxt;
  logic               own_r, own_nxt;
  logic               hit_r, hit_nxt;
  logic               upd_r, upd_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               out_valid_r, out_valid_nxt;
  hnl_pkg::out_item_t out_item_r, out_item_nxt;
  logic [7:0]         hold_timeout_r, hold_timeout_nxt;
  logic [31:0]        own_address_r, own_address_nxt;

  hnl_pkg::entry_t    head;
  logic               head_match;
  logic               head_newer;
  logic [32:0]        silence;
  logic               head_expired;
  logic               can_emit;
  logic               emit;
  hnl_pkg::out_item_t emit_item;
  logic [CNT_W-1:0]   back_pos;
  logic [IDX_W-1:0]   back_idx;

  // head cell checks
  assign head       = cells[0];
  assign head_match = (head.address == req_r.source_address);
  assign head_newer = (req_r.hello_sequence > head.seq_num);
  assign silence    = {1'b0, req_r.current_time} - {1'b0, head.heard_time};
  assign head_expired = !silence[32] && (silence[31:0] > {24'd0, hold_timeout_r});

  // back of the unscanned run during a tick
  assign back_pos = left_r - ONE;
  assign back_idx = back_pos[IDX_W-1:0];

  assign can_emit = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    own_nxt   = own_r;
    hit_nxt   = hit_r;
    upd_nxt   = upd_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    emit_item = '0;
    ctl.op    = hnl_pkg::OP_HOLD;
    ctl.wrap  = head;
    ctl.back  = cells[back_idx];
    ctl.fresh = {req_r.source_address, req_r.hello_sequence, req_r.current_time};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          own_nxt  = 1'b0;
          hit_nxt  = 1'b0;
          upd_nxt  = 1'b0;
          left_nxt = count_r;
          if (in_data.req_type == hnl_pkg::REQ_TICK) begin
            state_nxt = S_TICK;
          end else if (in_data.source_address == own_address_r) begin
            own_nxt   = 1'b1;
            state_nxt = S_REPLY;
          end else if (count_r == '0) begin
            state_nxt = S_REPLY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one full turn of the table past the head cell
        ctl.op = hnl_pkg::OP_ROTATE;
        if (head_match) begin
          hit_nxt = 1'b1;
          upd_nxt = head_newer;
          if (head_newer) begin
            ctl.wrap = {head.address, req_r.hello_sequence, req_r.current_time};
          end
        end
        left_nxt = left_r - ONE;
        if (left_r == ONE) begin
          state_nxt = S_REPLY;
        end
      end
      S_REPLY: begin
        if (can_emit) begin
          emit                        = 1'b1;
          emit_item.neighbour_address = req_r.source_address;
          emit_item.last_of_run       = 1'b1;
          if (own_r) begin
            emit_item.event_kind = hnl_pkg::EV_DONE;
          end else if (hit_r) begin
            emit_item.event_kind = upd_r ? hnl_pkg::EV_REFRESHED : hnl_pkg::EV_STALE;
          end else if (count_r == MAX_CNT) begin
            emit_item.event_kind = hnl_pkg::EV_FULL;
          end else begin
            emit_item.event_kind = hnl_pkg::EV_NEW;
            ctl.op               = hnl_pkg::OP_APPEND;
            count_nxt            = count_r + ONE;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (left_r == '0) begin
          if (can_emit) begin
            emit                 = 1'b1;
            emit_item.event_kind = hnl_pkg::EV_DONE;
            emit_item.last_of_run = 1'b1;
            state_nxt            = S_IDLE;
          end
        end else if (head_expired) begin
          if (can_emit) begin
            emit                        = 1'b1;
            emit_item.event_kind        = hnl_pkg::EV_TIMED_OUT;
            emit_item.neighbour_address = head.address;
            ctl.op                      = hnl_pkg::OP_DROP;
            count_nxt                   = count_r - ONE;
            left_nxt                    = left_r - ONE;
          end
        end else begin
          // kept entry moves behind the other kept ones
          ctl.op   = hnl_pkg::OP_ROTATE;
          left_nxt = left_r - ONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration writes
  always_comb begin
    hold_timeout_nxt = hold_timeout_r;
    own_address_nxt  = own_address_r;
    if (cfg_we) begin
      case (cfg_index)
        hnl_pkg::CFG_HOLD_TIMEOUT: hold_timeout_nxt = cfg_wdata[7:0];
        hnl_pkg::CFG_OWN_ADDRESS:  own_address_nxt  = cfg_wdata;
        default: begin
          hold_timeout_nxt = hold_timeout_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      hold_timeout_r <= hnl_pkg::HOLD_TIMEOUT_RST;
      own_address_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      out_valid_r    <= out_valid_nxt;
      hold_timeout_r <= hold_timeout_nxt;
      own_address_r  <= own_address_nxt;
    end
  end

  // transaction and scan payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    own_r      <= own_nxt;
    hit_r      <= hit_nxt;
    upd_r      <= upd_nxt;
    left_r     <= left_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign count     = count_r;
  assign unscanned = left_r;

  // checks
  `HNL_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, count_r <= MAX_CNT, "table count overflow")
  `HNL_ASSERT_NOW(a_left_le_count, clk, rst_n, state_r == S_TICK, left_r <= count_r, "scan beyond table")
  `HNL_ASSERT_NEXT(a_drop_reports, clk, rst_n, ctl.op == hnl_pkg::OP_DROP, out_valid_r && (out_item_r.event_kind == hnl_pkg::EV_TIMED_OUT), "removal without report")
  `HNL_ASSERT_NEXT(a_append_reports, clk, rst_n, ctl.op == hnl_pkg::OP_APPEND, out_valid_r && (out_item_r.event_kind == hnl_pkg::EV_NEW) && (count_r != '0), "append without report")

endmodule

// ----- design/hello_neighbor_liveness_table_unit.sv -----
// Neighbor table kept in a row of cells, one entry per cell, packed from cell 0. Items are
// taken one at a time (in_stall is high while one is in work). A hello runs one full turn of
// the table past the head cell, one entry per cycle, then reports; an empty table or a hello
// from the node's own address goes straight to the report. A tick also walks the head cell
// one entry per cycle while no result waits on a stalled output, kept entries rotating to the
// back and timed-out ones dropped with the back of the unscanned run moving into the head,
// then closes with a done result. Either kind also waits while the result side stalls with a
// result of it ready to go out. A result register sits on the output, so one result may wait
// there while work goes on.
module hello_neighbor_liveness_table_unit #(
  parameter int MAX_NEIGHBOURS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hnl_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hnl_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [hnl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

  hnl_pkg::entry_t    cell_q [MAX_NEIGHBOURS];
  hnl_pkg::entry_t    next_q [MAX_NEIGHBOURS];
  hnl_pkg::cell_ctl_t ctl;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   unscanned;

  // row of entry cells, each fed by its upper neighbor
  for (genvar k = 0; k < MAX_NEIGHBOURS; k++) begin : g_cell
    if (k < MAX_NEIGHBOURS - 1) begin : g_link
      assign next_q[k] = cell_q[k+1];
    end else begin : g_end
      assign next_q[k] = cell_q[k];
    end

    hnl_cell #(
      .K     (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .unscanned (unscanned),
      .next_q    (next_q[k]),
      .q         (cell_q[k])
    );
  end

  // sequencer, configuration and result register
  hnl_seq #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cells     (cell_q),
    .ctl       (ctl),
    .count     (count),
    .unscanned (unscanned)
  );

endmodule
